[rtl/core/stunp_pkg.sv]
// ----------------------------------------------------------------------------
// STUN parser package
// Shared types and constants for the STUN binding response parser.
// ----------------------------------------------------------------------------
package stunp_pkg;

    localparam logic [31:0] STUN_COOKIE       = 32'h2112A442;
    localparam logic [15:0] TYPE_SUCCESS      = 16'h0101;
    localparam logic [15:0] TYPE_ERROR        = 16'h0111;
    localparam logic [15:0] ATTR_MAPPED       = 16'h0001;
    localparam logic [15:0] ATTR_XOR_MAPPED   = 16'h0020;
    localparam logic [7:0]  FAMILY_IPV4       = 8'h01;
    localparam logic [16:0] HEADER_BYTES      = 17'd20;
    localparam logic [16:0] COUNT_MAX         = 17'h1FFFF;
    localparam logic [15:0] MAX_LENGTH_RESET  = 16'd1500;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_TOO_SHORT  = 3'd1,
        STATUS_BAD_COOKIE = 3'd2,
        STATUS_TOO_LONG   = 3'd3,
        STATUS_ERROR_RESP = 3'd4,
        STATUS_BAD_TYPE   = 3'd5,
        STATUS_NO_ADDRESS = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PHASE_HEADER = 2'd0,
        PHASE_VALUE  = 2'd1
    } phase_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] ipv4;
        logic [15:0] port;
    } result_t;

endpackage

[rtl/core/stunp_parse.sv]
// ----------------------------------------------------------------------------
// STUN parser datagram state
// Holds the per-datagram header and attribute walk state, advances it by one
// byte per step and forms the result for the final byte of a datagram.
// ----------------------------------------------------------------------------
module stunp_parse
    import stunp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  byte_in,
    input  logic        last_in,
    input  logic [15:0] max_length,
    output result_t     result
);

    logic [16:0] byte_count_reg,    byte_count_next;
    logic [15:0] header_type_reg,   header_type_next;
    logic [15:0] header_length_reg, header_length_next;
    logic [31:0] cookie_reg,        cookie_next;
    phase_t      phase_reg,         phase_next;
    logic [15:0] attr_kind_reg,     attr_kind_next;
    logic [15:0] attr_size_reg,     attr_size_next;
    logic [15:0] attr_offset_reg,   attr_offset_next;
    logic [7:0]  family_reg,        family_next;
    logic [15:0] port_shift_reg,    port_shift_next;
    logic [31:0] ip_shift_reg,      ip_shift_next;
    logic [15:0] best_port_reg,     best_port_next;
    logic [31:0] best_ip_reg,       best_ip_next;
    logic        found_reg,         found_next;
    logic        stopped_reg,       stopped_next;

    logic [17:0] msg_end;
    logic [16:0] padded_cur;
    logic [16:0] padded_new;
    logic [15:0] offset_inc;
    logic        in_walk;
    logic        is_xor;
    logic        is_mapped;
    status_t     status;

    assign msg_end    = 18'd20 + {2'b00, header_length_reg};
    assign padded_cur = ({1'b0, attr_size_reg} + 17'd3) & ~17'd3;
    assign padded_new = ({1'b0, attr_size_next} + 17'd3) & ~17'd3;
    assign offset_inc = attr_offset_reg + 16'd1;
    assign in_walk    = (byte_count_reg >= HEADER_BYTES) && !stopped_reg
                        && ({1'b0, byte_count_reg} < msg_end);
    assign is_xor     = (attr_kind_reg == ATTR_XOR_MAPPED);
    assign is_mapped  = (attr_kind_reg == ATTR_MAPPED);

    always_comb
    begin
        header_type_next   = header_type_reg;
        header_length_next = header_length_reg;
        cookie_next        = cookie_reg;
        phase_next         = phase_reg;
        attr_kind_next     = attr_kind_reg;
        attr_size_next     = attr_size_reg;
        attr_offset_next   = attr_offset_reg;
        family_next        = family_reg;
        port_shift_next    = port_shift_reg;
        ip_shift_next      = ip_shift_reg;
        best_port_next     = best_port_reg;
        best_ip_next       = best_ip_reg;
        found_next         = found_reg;
        stopped_next       = stopped_reg;

        if (byte_count_reg < 17'd2)
        begin
            header_type_next = {header_type_reg[7:0], byte_in};
        end
        else if (byte_count_reg < 17'd4)
        begin
            header_length_next = {header_length_reg[7:0], byte_in};
        end
        else if (byte_count_reg < 17'd8)
        begin
            cookie_next = {cookie_reg[23:0], byte_in};
        end
        else if (in_walk)
        begin
            case (phase_reg)
                PHASE_HEADER:
                begin
                    case (attr_offset_reg[1:0])
                        2'd0:    attr_kind_next = {byte_in, 8'h00};
                        2'd1:    attr_kind_next = attr_kind_reg | {8'h00, byte_in};
                        2'd2:    attr_size_next = {byte_in, 8'h00};
                        default: attr_size_next = attr_size_reg | {8'h00, byte_in};
                    endcase
                    if (attr_offset_reg < 16'd3)
                    begin
                        attr_offset_next = offset_inc;
                    end
                    else
                    begin
                        attr_offset_next = 16'd0;
                        family_next      = 8'h00;
                        port_shift_next  = 16'h0000;
                        ip_shift_next    = 32'h0;
                        if ({1'b0, byte_count_reg} + 18'd1 + {1'b0, padded_new} > msg_end)
                        begin
                            stopped_next = 1'b1;
                        end
                        else if (padded_new != 17'd0)
                        begin
                            phase_next = PHASE_VALUE;
                        end
                    end
                end
                PHASE_VALUE:
                begin
                    if (attr_offset_reg == 16'd1)
                    begin
                        family_next = byte_in;
                    end
                    else if (attr_offset_reg == 16'd2 || attr_offset_reg == 16'd3)
                    begin
                        port_shift_next = {port_shift_reg[7:0], byte_in};
                    end
                    else if (attr_offset_reg >= 16'd4 && attr_offset_reg < 16'd8)
                    begin
                        ip_shift_next = {ip_shift_reg[23:0], byte_in};
                    end
                    attr_offset_next = offset_inc;
                    if ({1'b0, offset_inc} >= padded_cur)
                    begin
                        phase_next       = PHASE_HEADER;
                        attr_offset_next = 16'd0;
                        if ((is_xor || is_mapped) && attr_size_reg >= 16'd4)
                        begin
                            best_port_next = port_shift_next
                                             ^ (is_xor ? STUN_COOKIE[31:16] : 16'h0000);
                            if (family_next == FAMILY_IPV4 && attr_size_reg == 16'd8)
                            begin
                                best_ip_next = ip_shift_next
                                               ^ (is_xor ? STUN_COOKIE : 32'h0);
                                found_next   = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PHASE_HEADER;
                end
            endcase
        end
    end

    assign byte_count_next = (byte_count_reg != COUNT_MAX) ? byte_count_reg + 17'd1
                                                           : byte_count_reg;

    always_comb
    begin
        if (byte_count_next < HEADER_BYTES)
            status = STATUS_TOO_SHORT;
        else if (cookie_next != STUN_COOKIE)
            status = STATUS_BAD_COOKIE;
        else if (header_length_next > max_length)
            status = STATUS_TOO_LONG;
        else if (header_type_next == TYPE_ERROR)
            status = STATUS_ERROR_RESP;
        else if (header_type_next != TYPE_SUCCESS)
            status = STATUS_BAD_TYPE;
        else if (!found_next)
            status = STATUS_NO_ADDRESS;
        else
            status = STATUS_OK;

        result.status = status;
        result.ipv4   = (status == STATUS_OK) ? best_ip_next : 32'h0;
        result.port   = (status == STATUS_OK) ? best_port_next : 16'h0000;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            header_type_reg   <= '0;
            header_length_reg <= '0;
            cookie_reg        <= '0;
            phase_reg         <= PHASE_HEADER;
            attr_kind_reg     <= '0;
            attr_size_reg     <= '0;
            attr_offset_reg   <= '0;
            family_reg        <= '0;
            port_shift_reg    <= '0;
            ip_shift_reg      <= '0;
            best_port_reg     <= '0;
            best_ip_reg       <= '0;
            found_reg         <= 1'b0;
            stopped_reg       <= 1'b0;
        end
        else if (step && last_in)
        begin
            byte_count_reg    <= '0;
            header_type_reg   <= '0;
            header_length_reg <= '0;
            cookie_reg        <= '0;
            phase_reg         <= PHASE_HEADER;
            attr_kind_reg     <= '0;
            attr_size_reg     <= '0;
            attr_offset_reg   <= '0;
            family_reg        <= '0;
            port_shift_reg    <= '0;
            ip_shift_reg      <= '0;
            best_port_reg     <= '0;
            best_ip_reg       <= '0;
            found_reg         <= 1'b0;
            stopped_reg       <= 1'b0;
        end
        else if (step)
        begin
            byte_count_reg    <= byte_count_next;
            header_type_reg   <= header_type_next;
            header_length_reg <= header_length_next;
            cookie_reg        <= cookie_next;
            phase_reg         <= phase_next;
            attr_kind_reg     <= attr_kind_next;
            attr_size_reg     <= attr_size_next;
            attr_offset_reg   <= attr_offset_next;
            family_reg        <= family_next;
            port_shift_reg    <= port_shift_next;
            ip_shift_reg      <= ip_shift_next;
            best_port_reg     <= best_port_next;
            best_ip_reg       <= best_ip_next;
            found_reg         <= found_next;
            stopped_reg       <= stopped_next;
        end
    end

endmodule

[rtl/core/stun_response_mapped_address_parser.sv]
// ----------------------------------------------------------------------------
// STUN binding response mapped address parser
// Parses a STUN datagram one byte per transaction and reports the status and
// the decoded public IPv4 address and port on the final byte.
// ----------------------------------------------------------------------------
// The parser takes one datagram byte per clock cycle unless input is held
// off, with no gaps needed between datagrams. Each byte is first held in an
// input register, the header and attribute state is advanced from that
// register, and the final byte of a datagram loads the result register.
// Input is held off only while a finished result waits to be taken and the
// byte in the input register is another final byte. The message length limit
// is written on its own channel and resets to 1500; the user must write it
// only while no datagram is in flight, which the block does not enforce.
module stun_response_mapped_address_parser
    import stunp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  status,
    output logic [31:0] mapped_ipv4,
    output logic [15:0] public_port
);

    logic        stage_valid_reg;
    logic        stage_last_reg;
    logic [7:0]  stage_byte_reg;
    logic [15:0] max_length_reg;
    logic        result_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        advance;

    assign advance    = !stage_valid_reg || !stage_last_reg || !result_valid_reg
                        || result_ready;
    assign data_ready = advance;
    assign cfg_ready  = 1'b1;

    stunp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (stage_valid_reg && advance),
        .byte_in    (stage_byte_reg),
        .last_in    (stage_last_reg),
        .max_length (max_length_reg),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            stage_last_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            max_length_reg   <= MAX_LENGTH_RESET;
        end
        else
        begin
            if (advance)
            begin
                stage_valid_reg <= data_valid;
                stage_last_reg  <= last_byte;
            end
            if (stage_valid_reg && stage_last_reg && advance)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (cfg_valid)
                max_length_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && data_valid)
            stage_byte_reg <= data_byte;
        if (stage_valid_reg && stage_last_reg && advance)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign status       = result_reg.status;
    assign mapped_ipv4  = result_reg.ipv4;
    assign public_port  = result_reg.port;

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !data_ready |-> (stage_valid_reg && stage_last_reg && result_valid_reg
                         && !result_ready))
        else $error("input held off without a waiting result");

    a_final_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && stage_last_reg && advance) |=> result_valid_reg)
        else $error("final byte did not produce a result");

    a_result_only_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        (!result_valid_reg || result_ready) && !(stage_valid_reg && stage_last_reg)
        |=> !result_valid_reg)
        else $error("result appeared without a final byte");

    a_failed_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.status != STATUS_OK)
        |-> (result_reg.ipv4 == 32'h0 && result_reg.port == 16'h0000))
        else $error("failed status carries an address");
`endif

endmodule

[tb/sv/stun_parser_scoreboard_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// STUN parser scoreboard
// Tracks the parser state byte by byte, predicts the result of each datagram
// and compares it with the result that the parser reports.
// ----------------------------------------------------------------------------
package stun_parser_scoreboard_pkg;

    import stunp_pkg::*;

    class mapped_address_scoreboard;

        result_t     expected_results[$];
        int          mismatches;

        bit [15:0]   length_limit;
        bit [16:0]   byte_count;
        bit [15:0]   hdr_type;
        bit [15:0]   msg_length;
        bit [31:0]   cookie;
        phase_t      phase;
        bit [15:0]   attr_kind;
        bit [15:0]   attr_size;
        bit [15:0]   attr_offset;
        bit [7:0]    family;
        bit [15:0]   port_acc;
        bit [31:0]   ip_acc;
        bit [15:0]   port_best;
        bit [31:0]   ip_best;
        bit          address_found;
        bit          walk_stopped;

        function new();
            mismatches = 0;
            length_limit = MAX_LENGTH_RESET;
            clear_datagram();
        endfunction

        function void clear_datagram();
            byte_count = '0;
            hdr_type = '0;
            msg_length = '0;
            cookie = '0;
            phase = PHASE_HEADER;
            attr_kind = '0;
            attr_size = '0;
            attr_offset = '0;
            family = '0;
            port_acc = '0;
            ip_acc = '0;
            port_best = '0;
            ip_best = '0;
            address_found = 1'b0;
            walk_stopped = 1'b0;
        endfunction

        function void set_limit(input bit [15:0] value);
            length_limit = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void commit_attribute();
            bit is_xor;
            is_xor = (attr_kind == ATTR_XOR_MAPPED);
            if (!is_xor && attr_kind != ATTR_MAPPED)
                return;
            if (attr_size < 16'd4)
                return;
            port_best = is_xor ? (port_acc ^ STUN_COOKIE[31:16]) : port_acc;
            if (family == FAMILY_IPV4 && attr_size == 16'd8)
            begin
                ip_best = is_xor ? (ip_acc ^ STUN_COOKIE) : ip_acc;
                address_found = 1'b1;
            end
        endfunction

        function void walk_attribute(input bit [16:0] idx, input bit [7:0] b);
            bit [31:0] padded;
            bit [31:0] message_end;
            padded = (32'(attr_size) + 32'd3) & ~32'd3;
            message_end = 32'(HEADER_BYTES) + 32'(msg_length);
            if (phase == PHASE_HEADER)
            begin
                case (attr_offset[1:0])
                    2'd0: attr_kind = {b, 8'h00};
                    2'd1: attr_kind = attr_kind | 16'(b);
                    2'd2: attr_size = {b, 8'h00};
                    default: attr_size = attr_size | 16'(b);
                endcase
                if (attr_offset < 16'd3)
                begin
                    attr_offset++;
                    return;
                end
                attr_offset = '0;
                family = '0;
                port_acc = '0;
                ip_acc = '0;
                padded = (32'(attr_size) + 32'd3) & ~32'd3;
                if (32'(idx) + 32'd1 + padded > message_end)
                begin
                    walk_stopped = 1'b1;
                    return;
                end
                if (padded == 32'd0)
                    commit_attribute();
                else
                    phase = PHASE_VALUE;
                return;
            end
            if (attr_offset == 16'd1)
                family = b;
            else if (attr_offset == 16'd2 || attr_offset == 16'd3)
                port_acc = {port_acc[7:0], b};
            else if (attr_offset >= 16'd4 && attr_offset < 16'd8)
                ip_acc = {ip_acc[23:0], b};
            attr_offset++;
            if (32'(attr_offset) >= padded)
            begin
                commit_attribute();
                phase = PHASE_HEADER;
                attr_offset = '0;
            end
        endfunction

        function void note_byte(input bit [7:0] b, input bit last);
            bit [16:0] idx;
            result_t   res;
            idx = byte_count;
            if (idx < 17'd2)
                hdr_type = {hdr_type[7:0], b};
            else if (idx < 17'd4)
                msg_length = {msg_length[7:0], b};
            else if (idx < 17'd8)
                cookie = {cookie[23:0], b};
            else if (idx >= HEADER_BYTES && !walk_stopped &&
                     32'(idx) < 32'(HEADER_BYTES) + 32'(msg_length))
                walk_attribute(idx, b);
            if (byte_count < COUNT_MAX)
                byte_count++;
            if (!last)
                return;
            if (byte_count < HEADER_BYTES)
                res.status = STATUS_TOO_SHORT;
            else if (cookie != STUN_COOKIE)
                res.status = STATUS_BAD_COOKIE;
            else if (msg_length > length_limit)
                res.status = STATUS_TOO_LONG;
            else if (hdr_type == TYPE_ERROR)
                res.status = STATUS_ERROR_RESP;
            else if (hdr_type != TYPE_SUCCESS)
                res.status = STATUS_BAD_TYPE;
            else if (!address_found)
                res.status = STATUS_NO_ADDRESS;
            else
                res.status = STATUS_OK;
            res.ipv4 = (res.status == STATUS_OK) ? ip_best : 32'd0;
            res.port = (res.status == STATUS_OK) ? port_best : 16'd0;
            expected_results.push_back(res);
            clear_datagram();
        endfunction

        task report_mismatch(input string msg);
            $display("ERROR: %s", msg);
            mismatches++;
        endtask

        task check_result(input logic [2:0] st, input logic [31:0] ip, input logic [15:0] port);
            result_t exp;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: status %0d ipv4 %08h port %04h",
                                          st, ip, port));
                return;
            end
            exp = expected_results.pop_front();
            if (st !== exp.status || ip !== exp.ipv4 || port !== exp.port)
                report_mismatch($sformatf("status %0d ipv4 %08h port %04h, expected %0d %08h %04h",
                                          st, ip, port, exp.status, exp.ipv4, exp.port));
        endtask

    endclass

endpackage

[tb/sv/stun_response_mapped_address_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// STUN mapped address parser testbench
// Feeds directed and random STUN datagrams through the byte channel under
// several length limits and idling patterns, and checks every result.
// ----------------------------------------------------------------------------
module stun_response_mapped_address_parser_tb;

    import stunp_pkg::*;
    import stun_parser_scoreboard_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 8;
    localparam logic [15:0] TYPE_REQUEST  = 16'h0001;
    localparam logic [15:0] ATTR_SOFTWARE = 16'h8022;
    localparam logic [7:0]  FAMILY_IPV6   = 8'h02;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        data_valid;
    logic        data_ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic        result_ready;
    logic [2:0]  status;
    logic [31:0] mapped_ipv4;
    logic [15:0] public_port;

    mapped_address_scoreboard sb;
    logic [7:0]  dgram[$];
    int          send_gap_pct;
    int          stall_pct;
    int          cycles;

    stun_response_mapped_address_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .data_valid   (data_valid),
        .data_ready   (data_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .mapped_ipv4  (mapped_ipv4),
        .public_port  (public_port)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_ready === 1'b1)
            sb.check_result(status, mapped_ipv4, public_port);

    function automatic void put16(input logic [15:0] v);
        dgram.push_back(v[15:8]);
        dgram.push_back(v[7:0]);
    endfunction

    function automatic void set_length(input logic [15:0] len);
        dgram[2] = len[15:8];
        dgram[3] = len[7:0];
    endfunction

    function automatic void put_header(input logic [15:0] kind, input logic [15:0] len,
                                       input logic [31:0] magic);
        dgram.delete();
        put16(kind);
        put16(len);
        put16(magic[31:16]);
        put16(magic[15:0]);
        repeat (12) dgram.push_back(8'($urandom));
    endfunction

    function automatic void put_attr(input logic [15:0] kind, input logic [15:0] size,
                                     input logic [7:0] fam, input logic [15:0] port,
                                     input logic [31:0] ip);
        int padded;
        put16(kind);
        put16(size);
        padded = (int'(size) + 3) & ~3;
        for (int i = 0; i < padded; i++)
        begin
            case (i)
                1: dgram.push_back(fam);
                2: dgram.push_back(port[15:8]);
                3: dgram.push_back(port[7:0]);
                4, 5, 6, 7: dgram.push_back(ip[8*(7-i) +: 8]);
                default: dgram.push_back(8'($urandom));
            endcase
        end
        set_length(16'(dgram.size() - 20));
    endfunction

    function automatic void build_random_datagram();
        int          sel;
        int          keep;
        logic [15:0] type_word;
        logic [15:0] kind;
        logic [15:0] size;
        logic [15:0] len;
        logic [31:0] magic;
        logic [7:0]  fam;
        sel = $urandom_range(0, 99);
        if (sel < 5)
        begin
            dgram.delete();
            repeat ($urandom_range(1, 28)) dgram.push_back(8'($urandom));
            return;
        end
        sel = $urandom_range(0, 99);
        type_word = (sel < 80) ? TYPE_SUCCESS : (sel < 88) ? TYPE_ERROR :
                    (sel < 92) ? TYPE_REQUEST : 16'($urandom);
        sel = $urandom_range(0, 99);
        magic = (sel < 90) ? STUN_COOKIE :
                (sel < 96) ? (STUN_COOKIE ^ (32'd1 << $urandom_range(0, 31))) : $urandom;
        put_header(type_word, 16'd0, magic);
        repeat ($urandom_range(0, 4))
        begin
            sel = $urandom_range(0, 99);
            kind = (sel < 45) ? ATTR_XOR_MAPPED : (sel < 80) ? ATTR_MAPPED :
                   (sel < 90) ? ATTR_SOFTWARE : 16'($urandom);
            sel = $urandom_range(0, 99);
            size = (sel < 70) ? 16'd8 : (sel < 80) ? 16'($urandom_range(4, 7)) :
                   (sel < 88) ? 16'($urandom_range(0, 3)) : (sel < 95) ? 16'd20 :
                   16'($urandom_range(9, 16));
            sel = $urandom_range(0, 99);
            fam = (sel < 80) ? FAMILY_IPV4 : (sel < 90) ? FAMILY_IPV6 : 8'($urandom);
            put_attr(kind, size, fam, 16'($urandom), $urandom);
        end
        len = 16'(dgram.size() - 20);
        sel = $urandom_range(0, 99);
        if (sel < 75)
            len = len;
        else if (sel < 83)
            len = len + 16'($urandom_range(1, 8));
        else if (sel < 91 && len >= 16'd4)
            len = len - 16'($urandom_range(1, 4));
        else if (sel < 96)
            len = 16'($urandom);
        else
            len = 16'd0;
        set_length(len);
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            keep = $urandom_range(1, dgram.size() - 1);
            while (dgram.size() > keep)
                void'(dgram.pop_back());
        end
        else if (sel < 16)
            repeat ($urandom_range(1, 8)) dgram.push_back(8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            data_valid <= 1'b0;
            @(negedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= last;
        do
            @(posedge clk);
        while (data_ready !== 1'b1);
        sb.note_byte(b, last);
        @(negedge clk);
    endtask

    task automatic send_datagram();
        for (int i = 0; i < dgram.size(); i++)
            send_byte(dgram[i], i == dgram.size() - 1);
    endtask

    task automatic wait_drained();
        data_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_limit(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        dgram.delete();
        dgram.push_back(8'hFF);
        send_datagram();
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        send_datagram();
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        void'(dgram.pop_back());
        send_datagram();
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE ^ 32'h0000_0001);
        send_datagram();
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        put_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'hFFFF, 32'hFFFF_FFFF);
        send_datagram();
        // The last address attribute wins over an earlier one.
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        put_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'hFFFF, 32'hFFFF_FFFF);
        put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0000, 32'h0000_0000);
        send_datagram();
        put_header(TYPE_ERROR, 16'd0, STUN_COOKIE);
        put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
        send_datagram();
        put_header(TYPE_REQUEST, 16'd0, STUN_COOKIE);
        put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
        send_datagram();
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
        set_length(MAX_LENGTH_RESET + 16'd1);
        send_datagram();
        // An attribute running past the declared message end stops the walk.
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        put_attr(ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
        put_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
        set_length(16'(dgram.size() - 24));
        send_datagram();
        // The datagram ends before the declared message end.
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        put_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
        void'(dgram.pop_back());
        void'(dgram.pop_back());
        send_datagram();
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        put_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
        repeat (6) dgram.push_back(8'($urandom));
        send_datagram();
        // Empty and unknown attributes change nothing; short and IPv6 address attributes update only the port.
        put_header(TYPE_SUCCESS, 16'd0, STUN_COOKIE);
        put_attr(ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'($urandom), $urandom);
        put_attr(ATTR_SOFTWARE, 16'd5, FAMILY_IPV4, 16'($urandom), $urandom);
        put_attr(ATTR_MAPPED, 16'd0, FAMILY_IPV4, 16'($urandom), $urandom);
        put_attr(ATTR_XOR_MAPPED, 16'd20, FAMILY_IPV6, 16'($urandom), $urandom);
        put_attr(ATTR_MAPPED, 16'd5, FAMILY_IPV6, 16'($urandom), $urandom);
        send_datagram();
    endtask

    task automatic run_phase(input logic [15:0] limit, input int gap_pct,
                             input int stall_in, input int budget);
        int sent;
        wait_drained();
        write_limit(limit);
        send_gap_pct = gap_pct;
        stall_pct = stall_in;
        sent = 0;
        while (sent < budget)
        begin
            build_random_datagram();
            send_datagram();
            sent += dgram.size();
        end
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        rst_n = 1'b0;
        data_valid = 1'b0;
        data_byte = 8'd0;
        last_byte = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 16'd0;
        result_ready = 1'b1;
        send_gap_pct = 0;
        stall_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_phase(16'hFFFF, 54, 0, 250);
        run_phase(16'($urandom_range(8, 64)), 0, 54, 220);
        run_phase(16'd0, 36, 36, 100);
        run_phase(16'($urandom), 0, 0, 200);
        run_phase(MAX_LENGTH_RESET, 36, 36, 280);
        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
